// ===== hdl/bbtk_pkg.sv =====
// ----------------------------------------------------------------------------
// bbtk_pkg
// Shared types, constants and helpers of the batch-balanced top-k selector.
// ----------------------------------------------------------------------------
package bbtk_pkg;

	localparam int CFG_W   = 4;
	localparam int AFF_W   = 32;
	localparam int COL_W   = 16;
	localparam int BATCH_W = 3;
	localparam int TOT_W   = 2 * CFG_W;

	localparam int DEF_MAX_BATCHES = 8;
	localparam int DEF_MAX_K       = 8;
	localparam int DEF_MAX_COLUMNS = 65536;

	localparam logic REG_BATCH_COUNT = 1'b0;
	localparam logic REG_PER_BATCH_K = 1'b1;

	typedef struct packed {
		logic insert;
		logic emit;
		logic clear;
	} bbtk_cmd_t;

	function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] max_v);
		logic [CFG_W-1:0] r;
		if (v == '0)
			r = CFG_W'(1);
		else if (v > max_v)
			r = max_v;
		else
			r = v;
		return r;
	endfunction

	function automatic logic ranks_above(input logic signed [AFF_W-1:0] sa,
		input logic [COL_W-1:0] ca, input logic signed [AFF_W-1:0] sb,
		input logic [COL_W-1:0] cb);
		return (sa > sb) || ((sa == sb) && (ca < cb));
	endfunction

endpackage

// ===== hdl/bbtk_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbtk_ctrl
// Collect / emit sequencer: takes columns, then issues one result per slot.
// ----------------------------------------------------------------------------
module bbtk_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_last,
	output logic                          in_ready,
	output logic                          out_valid,
	output logic                          out_last,
	input  logic                          out_ready,
	input  logic [bbtk_pkg::CFG_W-1:0]    nb,
	input  logic [bbtk_pkg::CFG_W-1:0]    kk,
	output bbtk_pkg::bbtk_cmd_t           cmd
);

	localparam logic ST_COLLECT = 1'b0;
	localparam logic ST_EMIT    = 1'b1;

	logic                          state_q;
	logic [bbtk_pkg::TOT_W-1:0]    idx_q;
	logic                          valid_q;
	logic                          last_q;
	logic [bbtk_pkg::TOT_W-1:0]    total;
	logic                          accept;
	logic                          adv;
	logic                          is_last;

	assign total    = bbtk_pkg::TOT_W'(nb) * bbtk_pkg::TOT_W'(kk);
	assign in_ready = (state_q == ST_COLLECT);
	assign accept   = in_valid && in_ready;
	assign adv      = (state_q == ST_EMIT) && (!valid_q || out_ready);
	assign is_last  = (idx_q + bbtk_pkg::TOT_W'(1)) == total;

	assign cmd.insert = accept;
	assign cmd.emit   = adv;
	assign cmd.clear  = adv && is_last;

	assign out_valid = valid_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			idx_q   <= '0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			if (adv) begin
				valid_q <= 1'b1;
				last_q  <= is_last;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					idx_q <= '0;
					if (accept && in_last)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (adv) begin
						if (is_last) begin
							idx_q   <= '0;
							state_q <= ST_COLLECT;
						end else begin
							idx_q <= idx_q + bbtk_pkg::TOT_W'(1);
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

endmodule

// ===== hdl/bbtk_datapath.sv =====
// ----------------------------------------------------------------------------
// bbtk_datapath
// Per-batch sorted lists with insertion, head merge tree and result register.
// ----------------------------------------------------------------------------
module bbtk_datapath #(
	parameter int MAX_BATCHES = bbtk_pkg::DEF_MAX_BATCHES,
	parameter int MAX_K       = bbtk_pkg::DEF_MAX_K,
	parameter int MAX_COLUMNS = bbtk_pkg::DEF_MAX_COLUMNS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bbtk_pkg::bbtk_cmd_t                  cmd,
	input  logic signed [bbtk_pkg::AFF_W-1:0]    affinity,
	input  logic [bbtk_pkg::BATCH_W-1:0]         batch,
	input  logic [bbtk_pkg::CFG_W-1:0]           nb,
	input  logic [bbtk_pkg::CFG_W-1:0]           kk,
	output logic [bbtk_pkg::COL_W-1:0]           column,
	output logic signed [bbtk_pkg::AFF_W-1:0]    score,
	output logic                                 present
);

	localparam int CC_W = $clog2(MAX_COLUMNS + 1);
	localparam int TK_W = $clog2(MAX_K + 1);
	localparam int LW   = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
	localparam int NL2  = 1 << $clog2(MAX_BATCHES);

	logic [CC_W-1:0]                     colcnt_q;
	logic                                store;
	logic [bbtk_pkg::COL_W-1:0]          cur_col;

	logic                                pres_q  [MAX_BATCHES][MAX_K];
	logic [bbtk_pkg::COL_W-1:0]          col_q   [MAX_BATCHES][MAX_K];
	logic signed [bbtk_pkg::AFF_W-1:0]   score_q [MAX_BATCHES][MAX_K];
	logic [TK_W-1:0]                     taken_q [MAX_BATCHES];

	logic                                nv [2*NL2];
	logic signed [bbtk_pkg::AFF_W-1:0]   ns [2*NL2];
	logic [bbtk_pkg::COL_W-1:0]          nc [2*NL2];
	logic [LW-1:0]                       nl [2*NL2];

	logic [bbtk_pkg::COL_W-1:0]          out_col_q;
	logic signed [bbtk_pkg::AFF_W-1:0]   out_score_q;
	logic                                out_pres_q;

	assign store   = (colcnt_q < CC_W'(MAX_COLUMNS)) &&
		({1'b0, batch} < nb);
	assign cur_col = bbtk_pkg::COL_W'(colcnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colcnt_q <= '0;
		end else if (cmd.clear) begin
			colcnt_q <= '0;
		end else if (cmd.insert && (colcnt_q < CC_W'(MAX_COLUMNS))) begin
			colcnt_q <= colcnt_q + CC_W'(1);
		end
	end

	for (genvar b = 0; b < MAX_BATCHES; b++) begin : g_lane
		logic ge [MAX_K];
		logic ins;
		logic pop;

		assign ins = cmd.insert && store && (batch == bbtk_pkg::BATCH_W'(b));
		assign pop = cmd.emit && nv[1] && (nl[1] == LW'(b));

		for (genvar j = 0; j < MAX_K; j++) begin : g_ge
			assign ge[j] = pres_q[b][j] && (score_q[b][j] >= affinity);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int j = 0; j < MAX_K; j++)
					pres_q[b][j] <= 1'b0;
				taken_q[b] <= '0;
			end else if (cmd.clear) begin
				for (int j = 0; j < MAX_K; j++)
					pres_q[b][j] <= 1'b0;
				taken_q[b] <= '0;
			end else if (pop) begin
				for (int j = 0; j < MAX_K - 1; j++)
					pres_q[b][j] <= pres_q[b][j+1];
				pres_q[b][MAX_K-1] <= 1'b0;
				taken_q[b] <= taken_q[b] + TK_W'(1);
			end else if (ins) begin
				for (int j = 0; j < MAX_K; j++) begin
					if ((bbtk_pkg::CFG_W'(j) < kk) && !ge[j]) begin
						if (j == 0 || ge[(j > 0) ? j - 1 : 0])
							pres_q[b][j] <= 1'b1;
						else
							pres_q[b][j] <= pres_q[b][(j > 0) ? j - 1 : 0];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (pop) begin
				for (int j = 0; j < MAX_K - 1; j++) begin
					col_q[b][j]   <= col_q[b][j+1];
					score_q[b][j] <= score_q[b][j+1];
				end
			end else if (ins) begin
				for (int j = 0; j < MAX_K; j++) begin
					if ((bbtk_pkg::CFG_W'(j) < kk) && !ge[j]) begin
						if (j == 0 || ge[(j > 0) ? j - 1 : 0]) begin
							col_q[b][j]   <= cur_col;
							score_q[b][j] <= affinity;
						end else begin
							col_q[b][j]   <= col_q[b][(j > 0) ? j - 1 : 0];
							score_q[b][j] <= score_q[b][(j > 0) ? j - 1 : 0];
						end
					end
				end
			end
		end
	end

	always_comb begin
		for (int n = 0; n < 2 * NL2; n++) begin
			nv[n] = 1'b0;
			ns[n] = '0;
			nc[n] = '0;
			nl[n] = '0;
		end
		for (int b = 0; b < MAX_BATCHES; b++) begin
			nv[NL2+b] = pres_q[b][0] && (bbtk_pkg::CFG_W'(taken_q[b]) < kk) &&
				(bbtk_pkg::CFG_W'(b) < nb);
			ns[NL2+b] = score_q[b][0];
			nc[NL2+b] = col_q[b][0];
			nl[NL2+b] = LW'(b);
		end
		for (int n = NL2 - 1; n >= 1; n--) begin
			if (nv[2*n] && (!nv[2*n+1] ||
				bbtk_pkg::ranks_above(ns[2*n], nc[2*n], ns[2*n+1], nc[2*n+1]))) begin
				nv[n] = nv[2*n];
				ns[n] = ns[2*n];
				nc[n] = nc[2*n];
				nl[n] = nl[2*n];
			end else begin
				nv[n] = nv[2*n+1];
				ns[n] = ns[2*n+1];
				nc[n] = nc[2*n+1];
				nl[n] = nl[2*n+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pres_q  <= nv[1];
			out_col_q   <= nv[1] ? nc[1] : '0;
			out_score_q <= nv[1] ? ns[1] : '0;
		end
	end

	assign column  = out_col_q;
	assign score   = out_score_q;
	assign present = out_pres_q;

endmodule

// ===== hdl/batch_balanced_topk_select.sv =====
// ----------------------------------------------------------------------------
// batch_balanced_topk_select
// Keeps the k best affinities of each batch over a row and emits them merged.
// ----------------------------------------------------------------------------
// One column is taken per cycle while a row is collected; each column of a
// batch below nb is ranked into its batch's sorted list in that cycle. After
// the column marked tlast, input stalls while nb * k results are emitted, one
// per cycle unless m_tready is low, from a merge tree over the list heads;
// nb and k are batch_count and per_batch_k clamped to 1..MAX. Slots without
// a neighbour come last with present cleared; the last result carries tlast.
module batch_balanced_topk_select #(
	parameter int MAX_BATCHES = bbtk_pkg::DEF_MAX_BATCHES,
	parameter int MAX_K       = bbtk_pkg::DEF_MAX_K,
	parameter int MAX_COLUMNS = bbtk_pkg::DEF_MAX_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] affinity
	input  logic [2:0]  s_tuser,   // [2:0] batch
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] column, [47:16] score
	output logic        m_tuser,   // [0] present
	output logic        m_tlast
);

	logic [bbtk_pkg::CFG_W-1:0]         batch_count_q;
	logic [bbtk_pkg::CFG_W-1:0]         per_batch_k_q;
	logic [bbtk_pkg::CFG_W-1:0]         nb;
	logic [bbtk_pkg::CFG_W-1:0]         kk;
	logic                               wr;
	bbtk_pkg::bbtk_cmd_t                cmd;
	logic [bbtk_pkg::COL_W-1:0]         column;
	logic signed [bbtk_pkg::AFF_W-1:0]  score;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_count_q <= bbtk_pkg::CFG_W'(1);
			per_batch_k_q <= bbtk_pkg::CFG_W'(1);
		end else if (wr) begin
			case (paddr[2])
				bbtk_pkg::REG_BATCH_COUNT: batch_count_q <= pwdata[bbtk_pkg::CFG_W-1:0];
				bbtk_pkg::REG_PER_BATCH_K: per_batch_k_q <= pwdata[bbtk_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bbtk_pkg::REG_BATCH_COUNT: prdata = 32'(batch_count_q);
			bbtk_pkg::REG_PER_BATCH_K: prdata = 32'(per_batch_k_q);
			default:                   prdata = '0;
		endcase
	end

	assign nb = bbtk_pkg::clamp_reg(batch_count_q, bbtk_pkg::CFG_W'(MAX_BATCHES));
	assign kk = bbtk_pkg::clamp_reg(per_batch_k_q, bbtk_pkg::CFG_W'(MAX_K));

	bbtk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_ready (m_tready),
		.nb        (nb),
		.kk        (kk),
		.cmd       (cmd)
	);

	bbtk_datapath #(
		.MAX_BATCHES (MAX_BATCHES),
		.MAX_K       (MAX_K),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.affinity (s_tdata),
		.batch    (s_tuser),
		.nb       (nb),
		.kk       (kk),
		.column   (column),
		.score    (score),
		.present  (m_tuser)
	);

	assign m_tdata = {score, column};

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of batch_balanced_topk_select. A table of directed columns comes
// first, then rows of random columns under a range of batch and k settings.
// An own model of the per-batch sorted lists predicts the merged winners of
// every row; each result transaction is checked field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int CFG_W     = bbtk_pkg::CFG_W;
	localparam int AFF_W     = bbtk_pkg::AFF_W;
	localparam int COL_W     = bbtk_pkg::COL_W;
	localparam int BATCH_W   = bbtk_pkg::BATCH_W;
	localparam int NB_MAX    = bbtk_pkg::DEF_MAX_BATCHES;
	localparam int K_MAX     = bbtk_pkg::DEF_MAX_K;
	localparam int COL_LIMIT = bbtk_pkg::DEF_MAX_COLUMNS;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] ADDR_BATCH_COUNT = 3'(4 * bbtk_pkg::REG_BATCH_COUNT);
	localparam logic [2:0] ADDR_PER_BATCH_K = 3'(4 * bbtk_pkg::REG_PER_BATCH_K);

	typedef struct {
		logic signed [AFF_W-1:0] aff;
		logic [BATCH_W-1:0]      batch;
		logic                    last;
	} column_t;

	typedef struct {
		logic [COL_W-1:0]        col;
		logic signed [AFF_W-1:0] score;
		logic                    present;
		logic                    final_res;
	} winner_t;

	typedef struct {
		column_t c;
		logic    typed;
		winner_t w;
	} row_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] affinity
	logic [2:0] s_tuser = '0;    // [2:0] batch
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;        // [15:0] column, [47:16] score
	logic m_tuser;               // [0] present
	logic m_tlast;

	batch_balanced_topk_select dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model state
	logic [CFG_W-1:0] batch_count_reg, per_batch_k_reg;
	logic held_present [NB_MAX*K_MAX];
	logic [COL_W-1:0] held_col [NB_MAX*K_MAX];
	logic signed [AFF_W-1:0] held_score [NB_MAX*K_MAX];
	int next_column;
	winner_t pending_winners[$];

	int fails = 0;
	bit calm = 0;
	bit squeeze = 0;

	function automatic int effective(logic [CFG_W-1:0] v, int max_v);
		if (v == 0)
			return 1;
		return (v > max_v) ? max_v : int'(v);
	endfunction

	function automatic bit outranks(logic signed [AFF_W-1:0] sa, logic [COL_W-1:0] ca,
		logic signed [AFF_W-1:0] sb, logic [COL_W-1:0] cb);
		return sa > sb || (sa == sb && ca < cb);
	endfunction

	function automatic void clear_lists();
		for (int s = 0; s < NB_MAX * K_MAX; s++) begin
			held_present[s] = 1'b0;
			held_col[s] = '0;
			held_score[s] = '0;
		end
	endfunction

	// Inserts one column into its batch list; on row end merges the lists into
	// the queue of expected winners.
	function automatic void rank_column(column_t c);
		int nb, kk, base, p, n, total;
		logic [COL_W-1:0] mcol [NB_MAX*K_MAX];
		logic signed [AFF_W-1:0] mscore [NB_MAX*K_MAX];
		winner_t w;
		nb = effective(batch_count_reg, NB_MAX);
		kk = effective(per_batch_k_reg, K_MAX);
		if (next_column < COL_LIMIT) begin
			if (c.batch < nb) begin
				base = c.batch * K_MAX;
				p = 0;
				while (p < kk && held_present[base+p] && held_score[base+p] >= c.aff)
					p++;
				if (p < kk) begin
					for (int i = kk - 1; i > p; i--) begin
						held_present[base+i] = held_present[base+i-1];
						held_col[base+i] = held_col[base+i-1];
						held_score[base+i] = held_score[base+i-1];
					end
					held_present[base+p] = 1'b1;
					held_col[base+p] = COL_W'(next_column);
					held_score[base+p] = c.aff;
				end
			end
			next_column++;
		end
		if (!c.last)
			return;
		n = 0;
		for (int b = 0; b < nb; b++)
			for (int j = 0; j < kk; j++)
				if (held_present[b*K_MAX+j]) begin
					p = n;
					while (p > 0 && outranks(held_score[b*K_MAX+j], held_col[b*K_MAX+j],
						mscore[p-1], mcol[p-1])) begin
						mscore[p] = mscore[p-1];
						mcol[p] = mcol[p-1];
						p--;
					end
					mscore[p] = held_score[b*K_MAX+j];
					mcol[p] = held_col[b*K_MAX+j];
					n++;
				end
		total = nb * kk;
		for (int i = 0; i < total; i++) begin
			w.present = (i < n);
			w.col = w.present ? mcol[i] : '0;
			w.score = w.present ? mscore[i] : '0;
			w.final_res = (i == total - 1);
			pending_winners.push_back(w);
		end
		clear_lists();
		next_column = 0;
	endfunction

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_BATCH_COUNT)
			batch_count_reg = value[CFG_W-1:0];
		else
			per_batch_k_reg = value[CFG_W-1:0];
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {28'd0, value[3:0]}) begin
			$error("prdata: expected %0h, got %0h", value[3:0], prdata);
			fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(int bc, int k);
		write_reg(ADDR_BATCH_COUNT, 32'(bc));
		write_reg(ADDR_PER_BATCH_K, 32'(k));
	endtask

	// Offers one column and waits for its transaction; s_tvalid stays high
	// between back-to-back items.
	task automatic send_column(column_t c);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c.aff;
		s_tuser <= c.batch;
		s_tlast <= c.last;
		do
			@(posedge clk);
		while (!s_tready);
		rank_column(c);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_winners.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [AFF_W-1:0] pick_affinity();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom;
		if (r < 85)
			return AFF_W'($signed($urandom_range(4)) - 2) <<< 16;
		case ($urandom_range(3))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh00000000;
			default: return -32'sd1;
		endcase
	endfunction

	task automatic random_rows(int n_items);
		int nb, len, sent;
		column_t c;
		nb = effective(batch_count_reg, NB_MAX);
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				c.aff = pick_affinity();
				c.batch = ($urandom_range(99) < 85) ? BATCH_W'($urandom_range(nb - 1))
					: BATCH_W'($urandom);
				c.last = (i == len - 1);
				send_column(c);
			end
			sent += len;
		end
	endtask

	// receiver
	int hold_left = 0;
	bit squeezed = 0;
	always @(negedge clk) begin
		if (squeeze && !squeezed) begin
			squeezed <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(99) >= 6;
		end
	end

	always @(posedge clk) begin
		winner_t w;
		if (m_tvalid && m_tready) begin
			if (pending_winners.size() == 0) begin
				$error("result transaction with no expected result: column %0d", m_tdata[15:0]);
				fails++;
			end else begin
				w = pending_winners.pop_front();
				if (m_tdata[15:0] !== w.col) begin
					$error("column: expected %0d, got %0d", w.col, m_tdata[15:0]);
					fails++;
				end
				if ($signed(m_tdata[47:16]) !== w.score) begin
					$error("score: expected %0d, got %0d", w.score, $signed(m_tdata[47:16]));
					fails++;
				end
				if (m_tuser !== w.present) begin
					$error("present: expected %0b, got %0b", w.present, m_tuser);
					fails++;
				end
				if (m_tlast !== w.final_res) begin
					$error("final_res: expected %0b, got %0b", w.final_res, m_tlast);
					fails++;
				end
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	row_step_t directed [] = '{
		// batch_count 1, k 1
		'{'{32'sh7fffffff, 3'd0, 1'b1}, 1'b1, '{16'd0, 32'sh7fffffff, 1'b1, 1'b1}},
		'{'{32'sh80000000, 3'd0, 1'b1}, 1'b1, '{16'd0, 32'sh80000000, 1'b1, 1'b1}},
		'{'{32'sh00000005, 3'd3, 1'b1}, 1'b1, '{16'd0, 32'sh0, 1'b0, 1'b1}},
		'{'{32'sh00000010, 3'd7, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh00000010, 3'd0, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh00000010, 3'd0, 1'b1}, 1'b1, '{16'd1, 32'sh10, 1'b1, 1'b1}},
		// batch_count 8, k 8 from here
		'{'{32'sh00010000, 3'd0, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh00010000, 3'd1, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh7fffffff, 3'd7, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh80000000, 3'd2, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'shffff0000, 3'd3, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh00010000, 3'd0, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh00000000, 3'd4, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh55555555, 3'd5, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'shaaaaaaaa, 3'd6, 1'b0}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh00010000, 3'd1, 1'b1}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}},
		'{'{32'sh00000001, 3'd2, 1'b1}, 1'b0, '{16'd0, 32'sh0, 1'b0, 1'b0}}
	};

	int bc_set [8] = '{3, 8, 1, 0, 15, 5, 2, 9};
	int k_set [8]  = '{4, 8, 8, 0, 15, 1, 7, 3};

	initial begin
		batch_count_reg = 4'd1;
		per_batch_k_reg = 4'd1;
		clear_lists();
		next_column = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (i == 6) begin
				drain();
				set_config(8, 8);
			end
			send_column(directed[i].c);
			if (directed[i].typed) begin
				void'(pending_winners.pop_back());
				pending_winners.push_back(directed[i].w);
			end
		end
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			set_config(bc_set[ph], k_set[ph]);
			calm = (ph == 2);
			squeeze = (ph == 1);
			random_rows(50);
			drain();
		end
		calm = 0;
		repeat (20) @(posedge clk);

		if (fails == 0 && pending_winners.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bbtk_pkg.sv
hdl/bbtk_ctrl.sv
hdl/bbtk_datapath.sv
hdl/batch_balanced_topk_select.sv
verif/tb.sv
